[hw/rtl/cellular_automaton_map_smoother_core_assert.svh]
// ----------------------------------------------------------------------------
// Map smoother assertion macros
// Shorthand for the clocked implication checks used by the block checker.
// ----------------------------------------------------------------------------
`ifndef CELLULAR_AUTOMATON_MAP_SMOOTHER_CORE_ASSERT_SVH
`define CELLULAR_AUTOMATON_MAP_SMOOTHER_CORE_ASSERT_SVH

// Same-cycle implication, quiet during reset
`define CAMSM_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, quiet during reset
`define CAMSM_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

// Next-cycle implication that also checks across reset
`define CAMSM_ASSERT_NXT_ALL(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) (ant) |=> (con)) else $error(msg);

`endif

[hw/rtl/camsm_pkg.sv]
// ----------------------------------------------------------------------------
// camsm_pkg
// Shared sizes, codes and structs of the cave map smoother.
// ----------------------------------------------------------------------------
package camsm_pkg;

  // Grid size and derived index widths
  localparam int MAP_COLS = 64;
  localparam int MAP_ROWS = 64;
  localparam int COL_W    = $clog2(MAP_COLS);
  localparam int ROW_W    = $clog2(MAP_ROWS);

  // Field and register widths
  localparam int ACT_W      = 2;
  localparam int COORD_W    = 6;
  localparam int RULE_W     = 4;
  localparam int CNT_W      = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [RULE_W-1:0] BIRTH_RESET   = RULE_W'(5);
  localparam logic [RULE_W-1:0] SURVIVE_RESET = RULE_W'(4);

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_PASS  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic {
    REG_BIRTH_MIN   = 1'b0,
    REG_SURVIVE_MIN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [RULE_W-1:0] birth_min;
    logic [RULE_W-1:0] survive_min;
  } rules_t;

  typedef struct packed {
    logic                rd_en;
    logic [COL_W-1:0]    rd_addr;
    logic                wr_en;
    logic [COL_W-1:0]    wr_addr;
    logic [MAP_ROWS-1:0] wr_data;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    logic cell_out;
    logic pass_done;
  } result_t;

endpackage

[hw/rtl/camsm_map_ram.sv]
// ----------------------------------------------------------------------------
// camsm_map_ram
// Cell store: one word per column, one bit per row, registered read.
// ----------------------------------------------------------------------------
module camsm_map_ram (
  input  logic                                clk,
  input  camsm_pkg::mem_req_t                 req,
  output logic [camsm_pkg::MAP_ROWS-1:0]      rd_data
);
  import camsm_pkg::*;

  logic [MAP_ROWS-1:0] mem [MAP_COLS];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

[hw/rtl/camsm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// camsm_cfg_regs
// APB-style register file holding the birth and survive thresholds.
// ----------------------------------------------------------------------------
module camsm_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [camsm_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [camsm_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [camsm_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                 cfg_pready,
  output camsm_pkg::rules_t                    rules
);
  import camsm_pkg::*;

  logic [RULE_W-1:0] birth_r;
  logic [RULE_W-1:0] survive_r;
  reg_idx_t          sel;
  logic              wr_beat;

  assign sel        = reg_idx_t'(cfg_paddr[2]);
  assign wr_beat    = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  // Write the addressed threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      birth_r   <= BIRTH_RESET;
      survive_r <= SURVIVE_RESET;
    end else if (wr_beat) begin
      unique case (sel)
        REG_BIRTH_MIN:   birth_r   <= cfg_pwdata[RULE_W-1:0];
        REG_SURVIVE_MIN: survive_r <= cfg_pwdata[RULE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (sel)
      REG_BIRTH_MIN:   cfg_prdata = CFG_DATA_W'(birth_r);
      REG_SURVIVE_MIN: cfg_prdata = CFG_DATA_W'(survive_r);
      default:         cfg_prdata = '0;
    endcase
  end

  assign rules.birth_min   = birth_r;
  assign rules.survive_min = survive_r;

endmodule

[hw/rtl/camsm_rule.sv]
// ----------------------------------------------------------------------------
// camsm_rule
// Counts the eight wall neighbours of one cell and applies birth/survive.
// ----------------------------------------------------------------------------
module camsm_rule (
  input  camsm_pkg::rules_t                 rules,
  input  logic [camsm_pkg::MAP_ROWS-1:0]    left_col,
  input  logic [camsm_pkg::MAP_ROWS-1:0]    mid_col,
  input  logic [camsm_pkg::MAP_ROWS-1:0]    right_col,
  input  logic [camsm_pkg::ROW_W-1:0]       row,
  output logic                              new_bit
);
  import camsm_pkg::*;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAP_ROWS - 1);

  logic [ROW_W-1:0] row_up;
  logic [ROW_W-1:0] row_dn;
  logic [7:0]       nb;
  logic [CNT_W-1:0] count;
  logic             wall;

  // Clamp the row neighbours to the grid edge
  assign row_up = (row == '0)       ? row : row - ROW_W'(1);
  assign row_dn = (row == ROW_LAST) ? row : row + ROW_W'(1);

  assign nb = {left_col[row_up],  left_col[row],  left_col[row_dn],
               mid_col[row_up],                   mid_col[row_dn],
               right_col[row_up], right_col[row], right_col[row_dn]};

  // Sum the neighbours
  always_comb begin
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + CNT_W'(nb[i]);
    end
  end

  assign wall    = mid_col[row];
  assign new_bit = wall ? (count >= rules.survive_min) : (count >= rules.birth_min);

endmodule

[hw/rtl/camsm_engine.sv]
// ----------------------------------------------------------------------------
// camsm_engine
// Sequencer: clears the store, serves cell reads and writes, and runs the
// in-place smoothing sweep through a three-column window.
// ----------------------------------------------------------------------------
module camsm_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [camsm_pkg::ACT_W-1:0]        in_action,
  input  logic [camsm_pkg::COORD_W-1:0]      in_col,
  input  logic [camsm_pkg::COORD_W-1:0]      in_row,
  input  logic                               in_cell_in,
  output logic                               in_stall,
  input  logic                               out_free,
  input  camsm_pkg::rules_t                  rules,
  input  logic [camsm_pkg::MAP_ROWS-1:0]     rd_data,
  output camsm_pkg::mem_req_t                mem_req,
  output camsm_pkg::result_t                 res
);
  import camsm_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_RD     = 10'b0000000100,
    S_RMW    = 10'b0000001000,
    S_LD0    = 10'b0000010000,
    S_LD1    = 10'b0000100000,
    S_CELL   = 10'b0001000000,
    S_COLEND = 10'b0010000000,
    S_NEXT   = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAP_COLS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAP_ROWS - 1);

  state_t              state_r, state_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic                cell_r, cell_nxt;
  logic [COL_W-1:0]    clr_r, clr_nxt;
  logic [MAP_ROWS-1:0] prev_r, prev_nxt;
  logic [MAP_ROWS-1:0] cur_r, cur_nxt;
  logic [MAP_ROWS-1:0] next_r, next_nxt;

  logic                accept;
  logic                in_range;
  action_t             act;
  logic [MAP_ROWS-1:0] left_col;
  logic [MAP_ROWS-1:0] right_col;
  logic [MAP_ROWS-1:0] rmw_word;
  logic                new_bit;

  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign act      = action_t'(in_action);
  assign in_range = (32'(in_col) < MAP_COLS) && (32'(in_row) < MAP_ROWS);

  // Window edges clamp onto the column being updated
  assign left_col  = (col_r == '0)       ? cur_r : prev_r;
  assign right_col = (col_r == COL_LAST) ? cur_r : next_r;

  camsm_rule u_rule (
    .rules     (rules),
    .left_col  (left_col),
    .mid_col   (cur_r),
    .right_col (right_col),
    .row       (row_r),
    .new_bit   (new_bit)
  );

  // Merge the written bit into the fetched column
  always_comb begin
    rmw_word        = rd_data;
    rmw_word[row_r] = cell_r;
  end

  // Next-state and memory control
  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    cell_nxt  = cell_r;
    clr_nxt   = clr_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    next_nxt  = next_r;
    mem_req   = '0;
    res       = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_r;
        mem_req.wr_data = '0;
        clr_nxt         = clr_r + COL_W'(1);
        if (clr_r == COL_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          col_nxt  = COL_W'(in_col);
          row_nxt  = ROW_W'(in_row);
          cell_nxt = in_cell_in;
          case (act) inside
            ACT_WRITE, ACT_READ: begin
              if (in_range) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = COL_W'(in_col);
                state_nxt       = (act == ACT_WRITE) ? S_RMW : S_RD;
              end else begin
                res.valid = 1'b1;
              end
            end
            ACT_PASS: begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = '0;
              col_nxt         = '0;
              row_nxt         = '0;
              state_nxt       = S_LD0;
            end
            default: begin
              res.valid = 1'b1;
            end
          endcase
        end
      end

      S_RD: begin
        if (out_free) begin
          res.valid    = 1'b1;
          res.cell_out = rd_data[row_r];
          state_nxt    = S_IDLE;
        end
      end

      S_RMW: begin
        if (out_free) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = col_r;
          mem_req.wr_data = rmw_word;
          res.valid       = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      S_LD0: begin
        cur_nxt         = rd_data;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = COL_W'(1);
        state_nxt       = S_LD1;
      end

      S_LD1: begin
        next_nxt  = rd_data;
        state_nxt = S_CELL;
      end

      S_CELL: begin
        cur_nxt[row_r] = new_bit;
        if (row_r == ROW_LAST) begin
          state_nxt = S_COLEND;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end

      S_COLEND: begin
        // Retire the finished column and slide the window
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = col_r;
        mem_req.wr_data = cur_r;
        prev_nxt        = cur_r;
        cur_nxt         = next_r;
        row_nxt         = '0;
        if (col_r == COL_LAST) begin
          state_nxt = S_DONE;
        end else begin
          col_nxt = col_r + COL_W'(1);
          if ((32'(col_r) + 2) < MAP_COLS) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = COL_W'(32'(col_r) + 2);
            state_nxt       = S_NEXT;
          end else begin
            state_nxt = S_CELL;
          end
        end
      end

      S_NEXT: begin
        next_nxt  = rd_data;
        state_nxt = S_CELL;
      end

      S_DONE: begin
        if (out_free) begin
          res.valid     = 1'b1;
          res.pass_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Coordinates and window columns
  always_ff @(posedge clk) begin
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    cell_r <= cell_nxt;
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    next_r <= next_nxt;
  end

endmodule

[hw/rtl/cellular_automaton_map_smoother_core.sv]
// ----------------------------------------------------------------------------
// cellular_automaton_map_smoother_core
// Cave map smoother: one-bit wall/floor grid with in-place smoothing passes.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one result beat. A cell write or read
// fetches its column first, then writes it back or selects the bit, and a
// write or read outside the grid, or the unused action code, answers from
// the idle state without a fetch. A smoothing pass walks one cell per cycle
// within a column through a three-column window fed by the column store,
// which has one read port and one write port. After reset the store is
// cleared one column per cycle, during which in_stall is high; register
// writes are taken meanwhile.
// ----------------------------------------------------------------------------
module cellular_automaton_map_smoother_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [camsm_pkg::ACT_W-1:0]         in_action,
  input  logic [camsm_pkg::COORD_W-1:0]       in_col,
  input  logic [camsm_pkg::COORD_W-1:0]       in_row,
  input  logic                                in_cell_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_cell_out,
  output logic                                out_pass_done,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [camsm_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [camsm_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [camsm_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);
  import camsm_pkg::*;

  rules_t              rules;
  mem_req_t            mem_req;
  logic [MAP_ROWS-1:0] rd_data;
  result_t             res;
  logic                out_free;
  logic                out_valid_r;
  logic                out_cell_r;
  logic                out_pass_r;

  camsm_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .rules       (rules)
  );

  camsm_map_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  camsm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_action  (in_action),
    .in_col     (in_col),
    .in_row     (in_row),
    .in_cell_in (in_cell_in),
    .in_stall   (in_stall),
    .out_free   (out_free),
    .rules      (rules),
    .rd_data    (rd_data),
    .mem_req    (mem_req),
    .res        (res)
  );

  // Output slot can take a result when empty or draining this cycle
  assign out_free = !out_valid_r || !out_stall;

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_cell_r <= res.cell_out;
      out_pass_r <= res.pass_done;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cell_out  = out_cell_r;
  assign out_pass_done = out_pass_r;

endmodule

[hw/rtl/camsm_checker.sv]
// ----------------------------------------------------------------------------
// camsm_checker
// Port-level checks of the map smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "cellular_automaton_map_smoother_core_assert.svh"

module camsm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [camsm_pkg::ACT_W-1:0]   in_action,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_cell_out,
  input logic                          out_pass_done
);
  import camsm_pkg::*;

  logic       in_beat;
  logic       noop_beat;
  logic       pass_beat;
  logic       out_held;
  logic [1:0] out_fields;

  assign in_beat    = in_valid && !in_stall;
  assign noop_beat  = in_beat && (in_action == ACT_NONE);
  assign pass_beat  = in_beat && (in_action == ACT_PASS);
  assign out_held   = out_valid && out_stall;
  assign out_fields = {out_cell_out, out_pass_done};

  // Store clearing holds off input right after reset
  `CAMSM_ASSERT_NXT_ALL(a_stall_after_reset, !rst_n, in_stall, "input taken during clear")

  // A result is either a read value or a pass completion, never both
  `CAMSM_ASSERT_IMP(a_result_exclusive, out_valid, !(&out_fields), "cell and pass both set")

  // Unused action code answers at once with an empty result
  `CAMSM_ASSERT_NXT(a_noop_result, noop_beat, out_valid && !(|out_fields), "no-op lost")

  // A pass holds off both sides on the next cycle
  `CAMSM_ASSERT_NXT(a_pass_busy, pass_beat, in_stall && !out_valid, "pass not busy")

  // A stalled result beat stays put
  `CAMSM_ASSERT_NXT(a_out_hold, out_held, out_valid && $stable(out_fields), "result moved")

endmodule

bind cellular_automaton_map_smoother_core camsm_checker u_camsm_checker (.*);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - cave map smoother regression
// Drives cell writes, cell reads and smoothing passes into the core under
// random idling on both sides, with one long output hold-off that fills the
// block. A shadow grid with its own birth/survive rules predicts every
// result beat, and each beat is checked field by field. The rule registers
// are read back after reset and rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb;
  import camsm_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 32;
  localparam int CHUNK_ITEMS = 22;
  localparam int CHUNKS      = 4;

  localparam logic [CFG_ADDR_W-1:0] ADDR_BIRTH   = CFG_ADDR_W'(4 * int'(REG_BIRTH_MIN));
  localparam logic [CFG_ADDR_W-1:0] ADDR_SURVIVE = CFG_ADDR_W'(4 * int'(REG_SURVIVE_MIN));

  typedef struct packed {
    logic cell_out;
    logic pass_done;
  } map_answer_t;

  // DUT ports
  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [ACT_W-1:0]      in_action     = '0;
  logic [COORD_W-1:0]    in_col        = '0;
  logic [COORD_W-1:0]    in_row        = '0;
  logic                  in_cell_in    = 1'b0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic                  out_cell_out;
  logic                  out_pass_done;
  logic                  cfg_psel      = 1'b0;
  logic                  cfg_penable   = 1'b0;
  logic                  cfg_pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr     = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata    = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Shadow grid and rules
  bit              shadow_map [MAP_COLS][MAP_ROWS];
  logic [RULE_W-1:0] rule_birth   = BIRTH_RESET;
  logic [RULE_W-1:0] rule_survive = SURVIVE_RESET;
  map_answer_t     pending_answers[$];

  // Run control and tallies
  bit  idle_on   = 1'b1;
  bit  hold_req  = 1'b0;
  int  cycle_cnt = 0;
  int  err_cnt   = 0;
  int  beats_sent = 0;
  int  passes_sent = 0;
  int  reads_sent = 0;
  int  beats_checked = 0;
  int  cfg_writes = 0;

  cellular_automaton_map_smoother_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_col        (in_col),
    .in_row        (in_row),
    .in_cell_in    (in_cell_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cell_out  (out_cell_out),
    .out_pass_done (out_pass_done),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding", $realtime,
               cycle_cnt, pending_answers.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // In-place smoothing pass on the shadow grid, column outer, row inner
  function automatic void smooth_shadow();
    int nc;
    int nr;
    int wall_cnt;
    for (int c = 0; c < MAP_COLS; c++) begin
      for (int r = 0; r < MAP_ROWS; r++) begin
        wall_cnt = 0;
        for (int dc = -1; dc <= 1; dc++) begin
          for (int dr = -1; dr <= 1; dr++) begin
            if (dc != 0 || dr != 0) begin
              nc = c + dc;
              nr = r + dr;
              if (nc < 0) nc = 0;
              else if (nc > MAP_COLS - 1) nc = MAP_COLS - 1;
              if (nr < 0) nr = 0;
              else if (nr > MAP_ROWS - 1) nr = MAP_ROWS - 1;
              wall_cnt += shadow_map[nc][nr];
            end
          end
        end
        if (!shadow_map[c][r] && wall_cnt >= int'(rule_birth)) shadow_map[c][r] = 1'b1;
        else if (shadow_map[c][r] && wall_cnt < int'(rule_survive)) shadow_map[c][r] = 1'b0;
      end
    end
  endfunction

  // Apply one accepted beat to the shadow grid and give its answer
  function automatic map_answer_t apply_map_beat(action_t act, int c, int r, logic val);
    map_answer_t ans;
    ans = '0;
    case (act)
      ACT_WRITE: begin
        if (c < MAP_COLS && r < MAP_ROWS) shadow_map[c][r] = val;
      end
      ACT_PASS: begin
        smooth_shadow();
        ans.pass_done = 1'b1;
      end
      ACT_READ: begin
        if (c < MAP_COLS && r < MAP_ROWS) ans.cell_out = shadow_map[c][r];
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Send one beat, with an optional random gap in front of it
  task automatic send_beat(action_t act, logic [COORD_W-1:0] c, logic [COORD_W-1:0] r,
                           logic val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_col     <= c;
    in_row     <= r;
    in_cell_in <= val;
    do @(posedge clk); while (in_stall);
    pending_answers.push_back(apply_map_beat(act, int'(c), int'(r), val));
    beats_sent++;
    if (act == ACT_PASS) passes_sent++;
    if (act == ACT_READ) reads_sent++;
  endtask

  // Drop valid and wait until every result beat is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_BIRTH) rule_birth = data[RULE_W-1:0];
    else if (addr == ADDR_SURVIVE) rule_survive = data[RULE_W-1:0];
    cfg_writes++;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_check(logic [CFG_ADDR_W-1:0] addr, logic [RULE_W-1:0] want);
    logic [CFG_DATA_W-1:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    if (got !== CFG_DATA_W'(want)) begin
      $display("%0t register at 0x%0h: expected 0x%0h actual 0x%0h", $realtime, addr,
               want, got);
      err_cnt++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rules(logic [RULE_W-1:0] birth, logic [RULE_W-1:0] survive);
    logic [CFG_DATA_W-RULE_W-1:0] junk;
    // Upper bits are junk on purpose: only the rule field must land
    junk = ($urandom_range(0, 1) == 0) ? '0 : (CFG_DATA_W-RULE_W)'($urandom);
    cfg_write(ADDR_BIRTH, {junk, birth});
    junk = ($urandom_range(0, 1) == 0) ? '0 : (CFG_DATA_W-RULE_W)'($urandom);
    cfg_write(ADDR_SURVIVE, {junk, survive});
    cfg_check(ADDR_BIRTH, birth);
    cfg_check(ADDR_SURVIVE, survive);
  endtask

  // Output stall: random bursts, plus one long hold-off on request
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    map_answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected result beat: actual cell_out %0b pass_done %0b",
                 $realtime, out_cell_out, out_pass_done);
        err_cnt++;
      end else begin
        want = pending_answers.pop_front();
        beats_checked++;
        if (out_cell_out !== want.cell_out) begin
          $display("%0t cell_out: expected %0b actual %0b", $realtime, want.cell_out,
                   out_cell_out);
          err_cnt++;
        end
        if (out_pass_done !== want.pass_done) begin
          $display("%0t pass_done: expected %0b actual %0b", $realtime, want.pass_done,
                   out_pass_done);
          err_cnt++;
        end
      end
    end
  end

  // Rule registers come up at their reset values
  task automatic test_register_reset();
    cfg_check(ADDR_BIRTH, BIRTH_RESET);
    cfg_check(ADDR_SURVIVE, SURVIVE_RESET);
  endtask

  // Corner writes and reads, a cleared cell, the unused action
  task automatic test_cell_access();
    send_beat(ACT_WRITE, 6'd0, 6'd0, 1'b1);
    send_beat(ACT_WRITE, 6'd63, 6'd63, 1'b1);
    send_beat(ACT_WRITE, 6'd0, 6'd63, 1'b1);
    send_beat(ACT_WRITE, 6'd63, 6'd0, 1'b1);
    send_beat(ACT_READ, 6'd0, 6'd0, 1'b0);
    send_beat(ACT_READ, 6'd63, 6'd63, 1'b1);
    send_beat(ACT_READ, 6'd0, 6'd63, 1'b0);
    send_beat(ACT_READ, 6'd63, 6'd0, 1'b1);
    send_beat(ACT_READ, 6'd21, 6'd42, 1'b0);
    send_beat(ACT_NONE, 6'd63, 6'd63, 1'b1);
    send_beat(ACT_WRITE, 6'd63, 6'd63, 1'b0);
    send_beat(ACT_READ, 6'd63, 6'd63, 1'b0);
    drain();
  endtask

  // Passes under the reset rule and under extreme rules
  task automatic test_pass_rules();
    send_beat(ACT_WRITE, 6'd1, 6'd0, 1'b1);
    send_beat(ACT_PASS, 6'd0, 6'd0, 1'b0);
    send_beat(ACT_READ, 6'd0, 6'd0, 1'b0);
    send_beat(ACT_READ, 6'd1, 6'd1, 1'b0);
    drain();
    // birth at zero fills every floor cell
    set_rules(4'd0, 4'd0);
    send_beat(ACT_PASS, 6'd42, 6'd21, 1'b1);
    send_beat(ACT_READ, 6'd30, 6'd30, 1'b0);
    drain();
    // out-of-range rules: no births, every wall dies
    set_rules(4'd15, 4'd9);
    send_beat(ACT_PASS, 6'd63, 6'd63, 1'b0);
    send_beat(ACT_READ, 6'd63, 6'd63, 1'b0);
    drain();
    set_rules(4'd8, 4'd15);
    send_beat(ACT_WRITE, 6'd5, 6'd5, 1'b1);
    send_beat(ACT_PASS, 6'd0, 6'd0, 1'b0);
    send_beat(ACT_READ, 6'd5, 6'd5, 1'b0);
    drain();
    set_rules(BIRTH_RESET, SURVIVE_RESET);
  endtask

  // Hold the output for a long stretch while beats keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 2 == 0)
        send_beat(ACT_WRITE, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
      else
        send_beat(ACT_READ, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
    end
    drain();
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(bit high_side);
    if ($urandom_range(0, 2) != 0)
      return high_side ? COORD_W'($urandom_range(58, 63)) : COORD_W'($urandom_range(0, 5));
    return COORD_W'($urandom);
  endfunction

  function automatic logic [RULE_W-1:0] pick_rule();
    if ($urandom_range(0, 9) < 7) return RULE_W'($urandom_range(2, 7));
    return RULE_W'($urandom);
  endfunction

  // Random beats in chunks, each under its own rules, scribbling near a corner
  task automatic test_random_map();
    bit      col_hi;
    bit      row_hi;
    int      pick;
    action_t act;
    for (int k = 0; k < CHUNKS; k++) begin
      if (k == CHUNKS - 1) idle_on = 1'b0;
      set_rules(pick_rule(), pick_rule());
      col_hi = 1'($urandom);
      row_hi = 1'($urandom);
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) act = ACT_WRITE;
        else if (pick < 85) act = ACT_READ;
        else if (pick < 93) act = ACT_PASS;
        else act = ACT_NONE;
        send_beat(act, pick_coord(col_hi), pick_coord(row_hi), 1'($urandom));
      end
      drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_reset();
    test_cell_access();
    test_pass_rules();
    test_backpressure();
    test_random_map();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d beats (%0d passes, %0d reads), %0d results checked, %0d rule writes",
             beats_sent, passes_sent, reads_sent, beats_checked, cfg_writes);
    $display("%0d mismatches over %0d cycles", err_cnt, cycle_cnt);
    if (err_cnt == 0 && pending_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/camsm_pkg.sv
hw/rtl/camsm_map_ram.sv
hw/rtl/camsm_cfg_regs.sv
hw/rtl/camsm_rule.sv
hw/rtl/camsm_engine.sv
hw/rtl/cellular_automaton_map_smoother_core.sv
hw/rtl/camsm_checker.sv
tb/tb.sv
